### rtl/chunk_reassembly_checker_top_macros.svh
// Assertion macros for the chunk reassembly checker.
// Used by chunk_reassembly_checker_top; expects i_clk and i_rst_n in scope.
`ifndef CHUNK_REASSEMBLY_CHECKER_TOP_MACROS_SVH
`define CHUNK_REASSEMBLY_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define CRCHK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chunk reassembly checker: implication violated");

// next-cycle implication
`define CRCHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chunk reassembly checker: next-cycle implication violated");

`endif

### rtl/crchk_pkg.sv
// Package for the chunk reassembly checker: transfer structs and codes.
// No dependencies.
`default_nettype none

package crchk_pkg;

    localparam logic [2:0] HDR_LEN = 3'd4;

    localparam logic [1:0] ST_REJECTED   = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_COMPLETE   = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        chunk_last;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [7:0]  write_byte;
        logic [15:0] write_offset;
        logic        status_valid;
        logic [1:0]  chunk_status;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/crchk_core.sv
// Chunk header parsing, transfer rules and per-byte result generation.
// Depends on crchk_pkg.
`default_nettype none

module crchk_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire crchk_pkg::t_in_item i_item,
    input  wire logic [31:0]         i_timeout_ms,
    output crchk_pkg::t_out_item     o_result
);

    logic        r_open,      n_open;
    logic [15:0] r_exp,       n_exp;
    logic [15:0] r_rcv,       n_rcv;
    logic [31:0] r_last_time, n_last_time;
    logic [2:0]  r_hdr_idx,   n_hdr_idx;
    logic [15:0] r_hdr_total, n_hdr_total;
    logic [15:0] r_hdr_off,   n_hdr_off;
    logic        r_acc,       n_acc;
    logic [15:0] r_pc,        n_pc;
    logic [31:0] r_chunk_time, n_chunk_time;

    always_comb begin
        logic [31:0] age;
        logic        timed_out;
        logic [15:0] hoff;
        logic [15:0] rcv_sum;

        n_open       = r_open;
        n_exp        = r_exp;
        n_rcv        = r_rcv;
        n_last_time  = r_last_time;
        n_hdr_idx    = r_hdr_idx;
        n_hdr_total  = r_hdr_total;
        n_hdr_off    = r_hdr_off;
        n_acc        = r_acc;
        n_pc         = r_pc;
        n_chunk_time = r_chunk_time;
        o_result     = '0;

        age       = r_chunk_time - r_last_time;
        timed_out = r_open && (age > i_timeout_ms);
        hoff      = {i_item.data_byte, r_hdr_off[7:0]};
        rcv_sum   = '0;

        if (r_hdr_idx != crchk_pkg::HDR_LEN) begin
            case (r_hdr_idx[1:0])
                2'd0: begin
                    n_chunk_time = i_item.now_ms;
                    n_hdr_total  = {8'd0, i_item.data_byte};
                end
                2'd1: begin
                    n_hdr_total = {i_item.data_byte, r_hdr_total[7:0]};
                end
                2'd2: begin
                    n_hdr_off = {8'd0, i_item.data_byte};
                end
                default: begin
                    n_hdr_off = hoff;
                    if (timed_out) begin
                        n_open = 1'b0;
                        n_exp  = '0;
                        n_rcv  = '0;
                    end
                    if (hoff == 16'd0) begin
                        n_open = 1'b1;
                        n_exp  = r_hdr_total;
                        n_rcv  = '0;
                    end
                    n_acc = n_open && (r_hdr_total == n_exp) && (hoff == n_rcv);
                    n_pc  = '0;
                end
            endcase
            n_hdr_idx = r_hdr_idx + 3'd1;
        end else begin
            if (r_acc) begin
                o_result.write_valid  = 1'b1;
                o_result.write_byte   = i_item.data_byte;
                o_result.write_offset = r_hdr_off + r_pc;
            end
            n_pc = r_pc + 16'd1;
        end

        if (i_item.chunk_last) begin
            o_result.status_valid = 1'b1;
            o_result.chunk_status = crchk_pkg::ST_REJECTED;
            if ((n_hdr_idx == crchk_pkg::HDR_LEN) && n_acc) begin
                rcv_sum     = n_rcv + n_pc;
                n_rcv       = rcv_sum;
                n_last_time = n_chunk_time;
                if (rcv_sum >= n_exp) begin
                    n_open                = 1'b0;
                    o_result.chunk_status = crchk_pkg::ST_COMPLETE;
                end else begin
                    o_result.chunk_status = crchk_pkg::ST_INCOMPLETE;
                end
            end
            n_hdr_idx = '0;
            n_acc     = 1'b0;
            n_pc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_exp        <= '0;
            r_rcv        <= '0;
            r_last_time  <= '0;
            r_hdr_idx    <= '0;
            r_hdr_total  <= '0;
            r_hdr_off    <= '0;
            r_acc        <= 1'b0;
            r_pc         <= '0;
            r_chunk_time <= '0;
        end else if (i_step) begin
            r_open       <= n_open;
            r_exp        <= n_exp;
            r_rcv        <= n_rcv;
            r_last_time  <= n_last_time;
            r_hdr_idx    <= n_hdr_idx;
            r_hdr_total  <= n_hdr_total;
            r_hdr_off    <= n_hdr_off;
            r_acc        <= n_acc;
            r_pc         <= n_pc;
            r_chunk_time <= n_chunk_time;
        end
    end

endmodule

`default_nettype wire

### rtl/chunk_reassembly_checker_top.sv
// Chunk reassembly checker: takes one chunk byte per cycle and gives one result per byte:
// an optional payload write and, on a chunk's last byte, its status. Each byte passes an
// input register, the combinational header and transfer-rule logic, and a result register;
// a new byte is taken every cycle while the output is not stalled.
// The timeout register resets to 3000 ms and takes a write only while the block is idle.
// Depends on crchk_pkg, crchk_core and chunk_reassembly_checker_top_macros.svh.
`default_nettype none

`include "chunk_reassembly_checker_top_macros.svh"

module chunk_reassembly_checker_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire crchk_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output crchk_pkg::t_out_item      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [31:0]          i_cfg_data
);

    logic                 r_in_valid;
    crchk_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    crchk_pkg::t_out_item r_out_data;
    logic [31:0]          r_timeout_ms;
    logic                 step;
    crchk_pkg::t_out_item result;

    assign step        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = !r_in_valid && !r_out_valid;

    crchk_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in_data),
        .i_timeout_ms (r_timeout_ms),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timeout_ms <= crchk_pkg::TIMEOUT_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout_ms <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (step) begin
            r_out_data <= result;
        end
    end

    `CRCHK_ASSERT_IMPL(a_no_write_zero, o_out_valid && !o_out_data.write_valid, o_out_data.write_byte == 8'd0 && o_out_data.write_offset == 16'd0)
    `CRCHK_ASSERT_IMPL(a_no_status_zero, o_out_valid && !o_out_data.status_valid, o_out_data.chunk_status == crchk_pkg::ST_REJECTED)
    `CRCHK_ASSERT_IMPL(a_stall_holds_item, o_in_stall, r_in_valid && !step)
    `CRCHK_ASSERT_NEXT(a_step_fills_out, step, r_out_valid)

endmodule

`default_nettype wire

### tb/tb_chunk_reassembly_checker_top.sv
// Testbench for chunk_reassembly_checker_top: random and directed chunk traffic, checked
// per byte against an in-bench predictor of the header and transfer rules.
// Depends on crchk_pkg and the chunk_reassembly_checker_top RTL.
`timescale 1ns / 100ps

module tb_chunk_reassembly_checker_top;

    localparam logic [31:0] TIMEOUT_STEPS [6] = '{crchk_pkg::TIMEOUT_RESET, 32'd0,
                                                  32'hFFFF_FFFF, 32'd100, 32'd1,
                                                  crchk_pkg::TIMEOUT_RESET};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    crchk_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    crchk_pkg::t_out_item o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [31:0]          i_cfg_data = '0;

    chunk_reassembly_checker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted block state
    logic [31:0] timeout_cfg = crchk_pkg::TIMEOUT_RESET;
    logic        xfer_open = 1'b0;
    logic [15:0] exp_total = '0;
    logic [15:0] rcvd_bytes = '0;
    logic [31:0] last_time = '0;
    logic [2:0]  hdr_idx = '0;
    logic [15:0] hdr_total = '0;
    logic [15:0] hdr_off = '0;
    logic        chunk_ok = 1'b0;
    logic [15:0] pay_cnt = '0;
    logic [31:0] chunk_t = '0;

    crchk_pkg::t_in_item  byte_queue[$];
    crchk_pkg::t_out_item pending_results[$];
    logic [31:0]          sim_ms;
    logic                 calm = 1'b0;

    int n_items = 0;
    int n_chunks = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_done = 0;
    int n_partial = 0;
    int n_rej = 0;
    int n_cfg = 0;
    int n_err = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("ERROR: run did not finish in time");
        $display("Verification failed");
        $finish;
    end

    function automatic crchk_pkg::t_out_item expected_for_byte(input crchk_pkg::t_in_item it);
        crchk_pkg::t_out_item r;
        logic [31:0]          age;
        r = '0;
        if (hdr_idx < crchk_pkg::HDR_LEN) begin
            case (hdr_idx)
                3'd0: begin
                    chunk_t = it.now_ms;
                    hdr_total = {8'h00, it.data_byte};
                end
                3'd1: hdr_total[15:8] = it.data_byte;
                3'd2: hdr_off = {8'h00, it.data_byte};
                default: begin
                    hdr_off[15:8] = it.data_byte;
                    age = chunk_t - last_time;
                    if (xfer_open && age > timeout_cfg) begin
                        xfer_open = 1'b0;
                        exp_total = '0;
                        rcvd_bytes = '0;
                    end
                    if (hdr_off == 16'd0) begin
                        xfer_open = 1'b1;
                        exp_total = hdr_total;
                        rcvd_bytes = '0;
                    end
                    chunk_ok = xfer_open && hdr_total == exp_total && hdr_off == rcvd_bytes;
                    pay_cnt = '0;
                end
            endcase
            hdr_idx = hdr_idx + 3'd1;
        end else begin
            if (chunk_ok) begin
                r.write_valid = 1'b1;
                r.write_byte = it.data_byte;
                r.write_offset = hdr_off + pay_cnt;
            end
            pay_cnt = pay_cnt + 16'd1;
        end
        if (it.chunk_last) begin
            r.status_valid = 1'b1;
            r.chunk_status = crchk_pkg::ST_REJECTED;
            if (hdr_idx >= crchk_pkg::HDR_LEN && chunk_ok) begin
                rcvd_bytes = rcvd_bytes + pay_cnt;
                last_time = chunk_t;
                if (rcvd_bytes >= exp_total) begin
                    xfer_open = 1'b0;
                    r.chunk_status = crchk_pkg::ST_COMPLETE;
                end else begin
                    r.chunk_status = crchk_pkg::ST_INCOMPLETE;
                end
            end
            hdr_idx = '0;
            chunk_ok = 1'b0;
            pay_cnt = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h", n_results, what, got, want);
        n_err++;
    endtask

    task automatic check_result(input crchk_pkg::t_out_item got,
                                input crchk_pkg::t_out_item want);
        if (got.write_valid !== want.write_valid)
            report_mismatch("write_valid", got.write_valid, want.write_valid);
        if (got.write_byte !== want.write_byte)
            report_mismatch("write_byte", got.write_byte, want.write_byte);
        if (got.write_offset !== want.write_offset)
            report_mismatch("write_offset", got.write_offset, want.write_offset);
        if (got.status_valid !== want.status_valid)
            report_mismatch("status_valid", got.status_valid, want.status_valid);
        if (got.chunk_status !== want.chunk_status)
            report_mismatch("chunk_status", got.chunk_status, want.chunk_status);
    endtask

    // Driver: predicts each accepted byte, holds a stalled transfer steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(expected_for_byte(i_in_data));
            if (!(i_in_valid && o_in_stall)) begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99, 0) >= 26)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= byte_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        crchk_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("ERROR: result %0d arrived with nothing expected", n_results);
                    n_err++;
                end else begin
                    want = pending_results.pop_front();
                    check_result(o_out_data, want);
                    if (want.write_valid)
                        n_writes++;
                    if (want.status_valid) begin
                        case (want.chunk_status)
                            crchk_pkg::ST_COMPLETE:   n_done++;
                            crchk_pkg::ST_INCOMPLETE: n_partial++;
                            default:                  n_rej++;
                        endcase
                    end
                end
                n_results++;
            end
            i_out_stall <= !calm && ($urandom_range(99, 0) < 26);
        end
    end

    function automatic logic [31:0] bump_time();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 35)
            sim_ms = sim_ms;
        else if (sel < 70)
            sim_ms = sim_ms + $urandom_range(20, 1);
        else if (sel < 80)
            sim_ms = sim_ms + timeout_cfg;
        else if (sel < 90)
            sim_ms = sim_ms + timeout_cfg + 32'd1;
        else
            sim_ms = sim_ms + $urandom;
        return sim_ms;
    endfunction

    // cut > 0 ends the chunk early after that many bytes
    task automatic push_chunk(input logic [15:0] total, input logic [15:0] offset,
                              input int plen, input logic [31:0] t, input int cut);
        crchk_pkg::t_in_item it;
        logic [7:0]          hdr [4];
        int                  n;
        hdr[0] = total[7:0];
        hdr[1] = total[15:8];
        hdr[2] = offset[7:0];
        hdr[3] = offset[15:8];
        n = (cut > 0) ? cut : 4 + plen;
        for (int i = 0; i < n; i++) begin
            it.data_byte = (i < 4) ? hdr[i] : 8'($urandom);
            it.chunk_last = (i == n - 1);
            it.now_ms = (i == 0) ? t : $urandom;
            byte_queue.push_back(it);
        end
        n_items += n;
        n_chunks++;
    endtask

    task automatic send_transfer();
        logic [15:0] total;
        logic [15:0] sent;
        logic [15:0] off;
        logic [15:0] tot;
        int          plen;
        int          cut;
        int          bad;
        total = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(40, 0));
        sent = '0;
        for (int k = 0; k < 10 && (k == 0 || sent < total); k++) begin
            plen = $urandom_range(12, 0);
            off = sent;
            tot = total;
            cut = 0;
            bad = $urandom_range(19, 0);
            case (bad)
                0: off = sent + 16'($urandom_range(5, 1));
                1: tot = total + 16'd1;
                2: cut = $urandom_range(3, 1);
                default: ;
            endcase
            push_chunk(tot, off, plen, bump_time(), cut);
            if (bad > 2)
                sent = sent + 16'(plen);
        end
    endtask

    task automatic gen_traffic(input int target);
        int start;
        int sel;
        start = n_items;
        while (n_items - start < target) begin
            sel = $urandom_range(99, 0);
            if (sel < 70)
                send_transfer();
            else if (sel < 85)
                push_chunk(16'($urandom), 16'($urandom), 0, bump_time(), $urandom_range(3, 1));
            else
                push_chunk(16'($urandom), ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom),
                           $urandom_range(8, 0), bump_time(), 0);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        timeout_cfg = value;
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        sim_ms = $urandom;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_timeout(TIMEOUT_STEPS[ph]);
            end
            calm = (ph == 2);
            if (ph == 0) begin
                sim_ms = 32'hFFFF_FFF0;
                push_chunk(16'hFFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 1);
                push_chunk(16'h0000, 16'h0000, 0, 32'h0000_0000, 2);
                push_chunk(16'h1234, 16'h0000, 0, sim_ms, 3);
                push_chunk(16'd0, 16'd0, 0, sim_ms, 0);
                push_chunk(16'd3, 16'd0, 2, sim_ms, 0);
                // next chunk crosses the 32-bit time wrap, still inside the limit
                push_chunk(16'd3, 16'd2, 1, 32'h0000_0BA0, 0);
                push_chunk(16'd3, 16'd5, 0, 32'h0000_0BA0, 0);
                sim_ms = 32'h0000_0BA0;
            end
            if (ph == 2) begin
                // long accepted chunk back to back, then the chunk that completes it
                push_chunk(16'd300, 16'd0, 200, sim_ms, 0);
                push_chunk(16'd300, 16'd200, 100, sim_ms, 0);
            end
            gen_traffic(130);
        end
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d bytes in %0d chunks, %0d payload writes, %0d timeout writes",
                 n_items, n_chunks, n_writes, n_cfg);
        $display("Summary: chunk status %0d complete, %0d incomplete, %0d rejected; %0d errors",
                 n_done, n_partial, n_rej, n_err);
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
